[rtl/core/grid_mesh_normal_tangent_unit_assert.svh]
// assertion macros shared by the grid mesh normal tangent unit
`ifndef GRID_MESH_NORMAL_TANGENT_UNIT_ASSERT_SVH
`define GRID_MESH_NORMAL_TANGENT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// checked property, off while reset is held
`define GMNT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked property, also during reset
`define GMNT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GMNT_ASSERT(lbl, prop, msg)
`define GMNT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/gmnt_pkg.sv]
// shared types and constants of the grid mesh normal tangent unit
package gmnt_pkg;

    localparam int COL_W  = 6;
    localparam int ROW_W  = 16;
    localparam int IN_W   = 16;
    localparam int UNIT_W = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int STEP_W = 5;

    // register indexes
    localparam logic REG_GRID_COLUMNS = 1'b0;
    localparam logic REG_GRID_ROWS    = 1'b1;

    // one cell result as kept in the stores
    typedef struct packed {
        logic [2:0][UNIT_W-1:0] nrm;
        logic [2:0][UNIT_W-1:0] tan;
        logic                   deg;
    } t_res;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_RD_A,
        OP_RD_B,
        OP_CAP_B,
        OP_EDGE,
        OP_CROSS,
        OP_NLOAD,
        OP_NSHIFT,
        OP_NZERO,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV,
        OP_DIV_ST,
        OP_REP_RD
    } t_op;

    // source of an emitted result
    typedef enum logic [1:0] {
        SRC_CELL,
        SRC_ROW_START,
        SRC_FIRST_ROW,
        SRC_CORNER
    } t_src;

    typedef struct packed {
        t_op              op;
        logic [STEP_W-1:0] step;
        logic [1:0]       k;
        logic             vsel;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] ridx;
        logic             prev_we;
        logic             first_we;
        logic             save_rs;
        logic             save_co;
        logic             emit;
        t_src             src;
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic             out_last;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic in_range;
        logic out_busy;
    } t_stat;

endpackage

[rtl/core/gmnt_if.sv]
// vertex and result channel interfaces
interface gmnt_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [gmnt_pkg::IN_W-1:0]    pos_x;
    logic signed [gmnt_pkg::IN_W-1:0]    pos_y;
    logic signed [gmnt_pkg::IN_W-1:0]    pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface gmnt_out_if;
    logic                                valid;
    logic                                ready;
    logic [gmnt_pkg::COL_W-1:0]          point_column;
    logic [gmnt_pkg::ROW_W-1:0]          point_row;
    logic signed [gmnt_pkg::UNIT_W-1:0]  normal_x;
    logic signed [gmnt_pkg::UNIT_W-1:0]  normal_y;
    logic signed [gmnt_pkg::UNIT_W-1:0]  normal_z;
    logic signed [gmnt_pkg::UNIT_W-1:0]  tangent_x;
    logic signed [gmnt_pkg::UNIT_W-1:0]  tangent_y;
    logic signed [gmnt_pkg::UNIT_W-1:0]  tangent_z;
    logic                                degenerate;
    logic                                last_of_run;
    modport source (output valid, point_column, point_row, normal_x, normal_y, normal_z,
                    tangent_x, tangent_y, tangent_z, degenerate, last_of_run, input ready);
    modport sink (input valid, point_column, point_row, normal_x, normal_y, normal_z,
                  tangent_x, tangent_y, tangent_z, degenerate, last_of_run, output ready);
endinterface

[rtl/core/gmnt_ram.sv]
// generic single write port ram with registered read
module gmnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/gmnt_dp.sv]
// datapath: line store, edge and cross product, shared normalizer, result stores
module gmnt_dp #(
    parameter int MAX_COLUMNS    = 32,
    parameter int COORD_BITS     = 16,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gmnt_pkg::t_cmd                    i_cmd,
    output gmnt_pkg::t_stat                   o_stat,
    input  logic [gmnt_pkg::IN_W-1:0]         i_pos_x,
    input  logic [gmnt_pkg::IN_W-1:0]         i_pos_y,
    input  logic [gmnt_pkg::IN_W-1:0]         i_pos_z,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [gmnt_pkg::COL_W-1:0]        o_col,
    output logic [gmnt_pkg::ROW_W-1:0]        o_row,
    output gmnt_pkg::t_res                    o_res,
    output logic                              o_last
);
    localparam int CB  = COORD_BITS;
    localparam int F   = UNIT_FRAC_BITS;
    localparam int DW  = CB + 1;
    localparam int XW  = 2 * CB + 3;
    localparam int MW  = (XW > 31) ? XW : 31;
    localparam int NW  = 31 + F;
    localparam int UW  = F + 2;
    localparam int UNW = gmnt_pkg::UNIT_W;
    localparam int AW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int PW  = 3 * CB;
    localparam int RW  = $bits(gmnt_pkg::t_res);

    logic signed [CB-1:0] r_a [3];
    logic signed [CB-1:0] r_b [3];
    logic signed [CB-1:0] r_c [3];
    logic signed [DW-1:0] r_ab [3];
    logic signed [DW-1:0] r_ac [3];
    logic signed [XW-1:0] r_cr [3];
    logic [MW-1:0]        r_mag [3];
    logic [2:0]           r_neg;
    logic [61:0]          r_sum, r_x, r_rt, r_bit;
    logic [30:0]          r_rem;
    logic [F:0]           r_num, r_q;
    gmnt_pkg::t_res       r_cell, r_rs, r_co, r_out;
    logic                 r_ovalid, r_last;
    logic [gmnt_pkg::COL_W-1:0] r_ocol;
    logic [gmnt_pkg::ROW_W-1:0] r_orow;

    logic [PW-1:0]        prev_wdata, prev_rdata;
    logic [RW-1:0]        fr_rdata;
    logic signed [CB-1:0] prev_v [3];
    logic signed [30:0]   mul_a, mul_b;
    logic signed [61:0]   prod;
    logic [1:0]           xj;
    logic signed [XW-1:0] nl_v [3];
    logic [XW-1:0]        nl_abs [3];
    logic                 mag_hi;
    logic                 mag_29;
    logic                 mag_zero;
    logic [61:0]          sq_t;
    logic [NW-1:0]        dv_num;
    logic [31:0]          dv_t, dv_len, dv_r;
    logic                 dv_ge;
    logic [F:0]           q_clamp;
    logic signed [UW-1:0] q_signed;
    logic [UNW-1:0]       q_out;
    gmnt_pkg::t_res       emit_res;

    // line store of the previous row, one vertex per entry
    assign prev_wdata = {r_c[2], r_c[1], r_c[0]};
    gmnt_ram #(.WIDTH(PW), .DEPTH(MAX_COLUMNS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.prev_we),
        .i_waddr (i_cmd.col[AW-1:0]),
        .i_wdata (prev_wdata),
        .i_re    (i_cmd.op == gmnt_pkg::OP_RD_A || i_cmd.op == gmnt_pkg::OP_RD_B),
        .i_raddr (i_cmd.ridx[AW-1:0]),
        .o_rdata (prev_rdata)
    );

    // results of the first cell row, replayed for the last row
    gmnt_ram #(.WIDTH(RW), .DEPTH(MAX_COLUMNS)) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.first_we),
        .i_waddr (i_cmd.col[AW-1:0]),
        .i_wdata (r_cell),
        .i_re    (i_cmd.op == gmnt_pkg::OP_REP_RD),
        .i_raddr (i_cmd.ridx[AW-1:0]),
        .o_rdata (fr_rdata)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prev_v[i] = prev_rdata[i*CB +: CB];
        end
    end

    // shared multiplier: cross product terms or squares
    assign xj = i_cmd.step[2:1];
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.op == gmnt_pkg::OP_SQ) begin
            mul_a = {1'b0, r_mag[i_cmd.k][29:0]};
            mul_b = {1'b0, r_mag[i_cmd.k][29:0]};
        end else begin
            case (i_cmd.step[2:0])
                3'd0: begin mul_a = 31'(r_ab[1]); mul_b = 31'(r_ac[2]); end
                3'd1: begin mul_a = 31'(r_ab[2]); mul_b = 31'(r_ac[1]); end
                3'd2: begin mul_a = 31'(r_ab[2]); mul_b = 31'(r_ac[0]); end
                3'd3: begin mul_a = 31'(r_ab[0]); mul_b = 31'(r_ac[2]); end
                3'd4: begin mul_a = 31'(r_ab[0]); mul_b = 31'(r_ac[1]); end
                3'd5: begin mul_a = 31'(r_ab[1]); mul_b = 31'(r_ac[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end
    assign prod = mul_a * mul_b;

    // magnitude load for the normalizer
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nl_v[i]   = i_cmd.vsel ? XW'(r_ab[i]) : r_cr[i];
            nl_abs[i] = nl_v[i][XW-1] ? XW'(-nl_v[i]) : XW'(nl_v[i]);
        end
    end

    // range of the largest magnitude
    always_comb begin
        mag_hi   = 1'b0;
        mag_29   = 1'b0;
        mag_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            mag_hi   = mag_hi | (|r_mag[i][MW-1:30]);
            mag_29   = mag_29 | r_mag[i][29];
            mag_zero = mag_zero & (r_mag[i] == '0);
        end
    end
    assign o_stat.zero     = mag_zero;
    assign o_stat.in_range = !mag_hi && mag_29;
    assign o_stat.out_busy = r_ovalid && !i_out_ready;

    // square root step and division step
    assign sq_t   = r_rt + r_bit;
    assign dv_num = NW'({r_mag[i_cmd.k][29:0], F'(0)}) + NW'(r_rt[30:1]);
    assign dv_t   = {r_rem, r_num[F]};
    assign dv_len = {1'b0, r_rt[30:0]};
    assign dv_ge  = dv_t >= dv_len;
    assign dv_r   = dv_t - dv_len;

    // clamp and sign of one unit component
    always_comb begin
        q_clamp  = (r_q > ((F+1)'(1) << F)) ? ((F+1)'(1) << F) : r_q;
        q_signed = r_neg[i_cmd.k] ? signed'(UW'(q_clamp)) : -signed'(UW'(q_clamp));
        q_out    = UNW'(q_signed);
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            gmnt_pkg::OP_LATCH: begin
                r_c[0] <= CB'(i_pos_x);
                r_c[1] <= CB'(i_pos_y);
                r_c[2] <= CB'(i_pos_z);
            end
            gmnt_pkg::OP_RD_B: begin
                for (int i = 0; i < 3; i++) r_a[i] <= prev_v[i];
            end
            gmnt_pkg::OP_CAP_B: begin
                for (int i = 0; i < 3; i++) r_b[i] <= prev_v[i];
            end
            gmnt_pkg::OP_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    r_ab[i] <= DW'(r_b[i]) - DW'(r_a[i]);
                    r_ac[i] <= DW'(r_c[i]) - DW'(r_a[i]);
                end
                r_cell.deg <= 1'b0;
            end
            gmnt_pkg::OP_CROSS: begin
                if (i_cmd.step[0]) r_cr[xj] <= r_cr[xj] - XW'(prod);
                else               r_cr[xj] <= XW'(prod);
            end
            gmnt_pkg::OP_NLOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= MW'(nl_abs[i]);
                    r_neg[i] <= nl_v[i][XW-1];
                end
            end
            gmnt_pkg::OP_NSHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= mag_hi ? (r_mag[i] >> 1) : (r_mag[i] << 1);
                end
            end
            gmnt_pkg::OP_NZERO: begin
                if (i_cmd.vsel) r_cell.tan <= '0;
                else            r_cell.nrm <= '0;
                r_cell.deg <= 1'b1;
            end
            gmnt_pkg::OP_SQ: begin
                r_sum <= ((i_cmd.k == 2'd0) ? 62'd0 : r_sum) + 62'(prod);
            end
            gmnt_pkg::OP_SQRT_INIT: begin
                r_x   <= r_sum;
                r_rt  <= '0;
                r_bit <= 62'd1 << 60;
            end
            gmnt_pkg::OP_SQRT: begin
                if (r_x >= sq_t) begin
                    r_x  <= r_x - sq_t;
                    r_rt <= (r_rt >> 1) + r_bit;
                end else begin
                    r_rt <= r_rt >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            gmnt_pkg::OP_DIV_INIT: begin
                r_rem <= 31'(dv_num[NW-1:F+1]);
                r_num <= dv_num[F:0];
                r_q   <= '0;
            end
            gmnt_pkg::OP_DIV: begin
                r_rem <= dv_ge ? dv_r[30:0] : dv_t[30:0];
                r_num <= r_num << 1;
                r_q   <= {r_q[F-1:0], dv_ge};
            end
            gmnt_pkg::OP_DIV_ST: begin
                if (i_cmd.vsel) r_cell.tan[i_cmd.k] <= q_out;
                else            r_cell.nrm[i_cmd.k] <= q_out;
            end
            default: begin
            end
        endcase
    end

    // row start and corner results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs <= '0;
            r_co <= '0;
        end else begin
            if (i_cmd.save_rs) r_rs <= r_cell;
            if (i_cmd.save_co) r_co <= r_cell;
        end
    end

    // output register
    always_comb begin
        case (i_cmd.src)
            gmnt_pkg::SRC_CELL:      emit_res = r_cell;
            gmnt_pkg::SRC_ROW_START: emit_res = r_rs;
            gmnt_pkg::SRC_FIRST_ROW: emit_res = gmnt_pkg::t_res'(fr_rdata);
            gmnt_pkg::SRC_CORNER:    emit_res = r_co;
            default:                 emit_res = r_cell;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out  <= emit_res;
            r_ocol <= i_cmd.out_col;
            r_orow <= i_cmd.out_row;
            r_last <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_col       = r_ocol;
    assign o_row       = r_orow;
    assign o_res       = r_out;
    assign o_last      = r_last;
endmodule

[rtl/core/gmnt_ctrl.sv]
// controller: grid position, per-vertex sequence and result emission
`include "grid_mesh_normal_tangent_unit_assert.svh"
module gmnt_ctrl #(
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cfg_wr,
    input  logic [gmnt_pkg::COL_W-1:0]  i_cols,
    input  logic [gmnt_pkg::ROW_W-1:0]  i_rows,
    input  gmnt_pkg::t_stat             i_stat,
    output gmnt_pkg::t_cmd              o_cmd
);
    localparam int SW = gmnt_pkg::STEP_W;
    localparam int CW = gmnt_pkg::COL_W;
    localparam int RWD = gmnt_pkg::ROW_W;

    typedef enum logic [20:0] {
        S_IDLE   = 21'd1,
        S_WRP    = 21'd1 << 1,
        S_RDA    = 21'd1 << 2,
        S_RDB    = 21'd1 << 3,
        S_CAPB   = 21'd1 << 4,
        S_EDGE   = 21'd1 << 5,
        S_CROSS  = 21'd1 << 6,
        S_NLOAD  = 21'd1 << 7,
        S_NSHIFT = 21'd1 << 8,
        S_SQ     = 21'd1 << 9,
        S_SQRTI  = 21'd1 << 10,
        S_SQRT   = 21'd1 << 11,
        S_DIVI   = 21'd1 << 12,
        S_DIV    = 21'd1 << 13,
        S_DIVST  = 21'd1 << 14,
        S_FIN    = 21'd1 << 15,
        S_EMC    = 21'd1 << 16,
        S_EMRS   = 21'd1 << 17,
        S_REPRD  = 21'd1 << 18,
        S_REPEM  = 21'd1 << 19,
        S_EMCO   = 21'd1 << 20
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_col, n_col, r_idx, n_idx;
    logic [RWD-1:0]  r_row, n_row;
    logic [SW-1:0]   r_step, n_step;
    logic [1:0]      r_k, n_k;
    logic            r_vsel, n_vsel;
    logic            accept, do_adv, next_vec;
    logic [CW-1:0]   ac_col;
    logic [RWD-1:0]  ac_row;
    gmnt_pkg::t_cmd  cmd;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = o_ready && i_valid;
    assign ac_col  = (r_col >= i_cols) ? '0 : r_col;
    assign ac_row  = (r_row >= i_rows) ? '0 : r_row;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        n_idx    = r_idx;
        n_step   = r_step;
        n_k      = r_k;
        n_vsel   = r_vsel;
        do_adv   = 1'b0;
        next_vec = 1'b0;
        cmd          = '0;
        cmd.op       = gmnt_pkg::OP_NONE;
        cmd.src      = gmnt_pkg::SRC_CELL;
        cmd.step     = r_step;
        cmd.k        = r_k;
        cmd.vsel     = r_vsel;
        cmd.col      = r_col;
        cmd.ridx     = r_col;
        cmd.out_col  = r_col;
        cmd.out_row  = r_row - RWD'(1);
        cmd.out_last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.op = gmnt_pkg::OP_LATCH;
                    n_col  = ac_col;
                    n_row  = ac_row;
                    if (ac_row == '0) n_state = S_WRP;
                    else if (ac_col < i_cols - CW'(1)) n_state = S_RDA;
                    else n_state = S_EMRS;
                end
            end
            S_WRP: begin
                cmd.prev_we = 1'b1;
                do_adv      = 1'b1;
                n_state     = S_IDLE;
            end
            S_RDA: begin
                cmd.op  = gmnt_pkg::OP_RD_A;
                n_state = S_RDB;
            end
            S_RDB: begin
                cmd.op   = gmnt_pkg::OP_RD_B;
                cmd.ridx = r_col + CW'(1);
                n_state  = S_CAPB;
            end
            S_CAPB: begin
                cmd.op  = gmnt_pkg::OP_CAP_B;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                cmd.op      = gmnt_pkg::OP_EDGE;
                cmd.prev_we = 1'b1;
                n_step      = '0;
                n_state     = S_CROSS;
            end
            S_CROSS: begin
                cmd.op = gmnt_pkg::OP_CROSS;
                n_step = r_step + SW'(1);
                if (r_step == SW'(5)) begin
                    n_vsel  = 1'b0;
                    n_state = S_NLOAD;
                end
            end
            S_NLOAD: begin
                cmd.op  = gmnt_pkg::OP_NLOAD;
                n_state = S_NSHIFT;
            end
            S_NSHIFT: begin
                if (i_stat.zero) begin
                    cmd.op   = gmnt_pkg::OP_NZERO;
                    next_vec = 1'b1;
                end else if (i_stat.in_range) begin
                    n_k     = '0;
                    n_state = S_SQ;
                end else begin
                    cmd.op = gmnt_pkg::OP_NSHIFT;
                end
            end
            S_SQ: begin
                cmd.op = gmnt_pkg::OP_SQ;
                n_k    = r_k + 2'd1;
                if (r_k == 2'd2) n_state = S_SQRTI;
            end
            S_SQRTI: begin
                cmd.op  = gmnt_pkg::OP_SQRT_INIT;
                n_step  = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                cmd.op = gmnt_pkg::OP_SQRT;
                n_step = r_step + SW'(1);
                if (r_step == SW'(30)) begin
                    n_k     = '0;
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                cmd.op  = gmnt_pkg::OP_DIV_INIT;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                cmd.op = gmnt_pkg::OP_DIV;
                n_step = r_step + SW'(1);
                if (r_step == SW'(UNIT_FRAC_BITS)) n_state = S_DIVST;
            end
            S_DIVST: begin
                cmd.op = gmnt_pkg::OP_DIV_ST;
                if (r_k == 2'd2) begin
                    next_vec = 1'b1;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_DIVI;
                end
            end
            S_FIN: begin
                cmd.first_we = (r_row == RWD'(1));
                cmd.save_rs  = (r_col == '0);
                cmd.save_co  = (r_col == i_cols - CW'(2));
                n_state      = S_EMC;
            end
            S_EMC: begin
                if (!i_stat.out_busy) begin
                    cmd.emit = 1'b1;
                    do_adv   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_EMRS: begin
                cmd.prev_we = 1'b1;
                cmd.src     = gmnt_pkg::SRC_ROW_START;
                cmd.out_last = (r_row != i_rows - RWD'(1));
                if (!i_stat.out_busy) begin
                    cmd.emit = 1'b1;
                    if (r_row == i_rows - RWD'(1)) begin
                        n_idx   = '0;
                        n_state = S_REPRD;
                    end else begin
                        do_adv  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_REPRD: begin
                cmd.op   = gmnt_pkg::OP_REP_RD;
                cmd.ridx = r_idx;
                n_state  = S_REPEM;
            end
            S_REPEM: begin
                cmd.src      = gmnt_pkg::SRC_FIRST_ROW;
                cmd.out_col  = r_idx;
                cmd.out_row  = i_rows - RWD'(1);
                cmd.out_last = 1'b0;
                if (!i_stat.out_busy) begin
                    cmd.emit = 1'b1;
                    if (r_idx == i_cols - CW'(2)) begin
                        n_state = S_EMCO;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_REPRD;
                    end
                end
            end
            S_EMCO: begin
                cmd.src     = gmnt_pkg::SRC_CORNER;
                cmd.out_col = i_cols - CW'(1);
                cmd.out_row = i_rows - RWD'(1);
                if (!i_stat.out_busy) begin
                    cmd.emit = 1'b1;
                    do_adv   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // move from normal to tangent, or finish the cell
        if (next_vec) begin
            if (!r_vsel) begin
                n_vsel  = 1'b1;
                n_state = S_NLOAD;
            end else begin
                n_state = S_FIN;
            end
        end

        // step the grid position
        if (do_adv) begin
            if (r_col + CW'(1) >= i_cols) begin
                n_col = '0;
                n_row = (r_row + RWD'(1) >= i_rows) ? '0 : r_row + RWD'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end

        // a register write restarts the grid
        if (i_cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end
    end

    assign o_cmd = cmd;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_idx   <= '0;
            r_step  <= '0;
            r_k     <= '0;
            r_vsel  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_idx   <= n_idx;
            r_step  <= n_step;
            r_k     <= n_k;
            r_vsel  <= n_vsel;
        end
    end

    `GMNT_ASSERT(a_emit_when_free, cmd.emit |-> !i_stat.out_busy, "result emitted over a held one")
    `GMNT_ASSERT(a_one_vertex, accept |=> !o_ready, "second vertex taken while one is at work")
    `GMNT_ASSERT(a_col_bound, (r_state != S_IDLE) |-> (r_col < i_cols), "column beyond grid width")
    `GMNT_ASSERT(a_rep_bound, (r_state == S_REPEM) |-> (r_idx < i_cols - CW'(1)), "replay overrun")
endmodule

[rtl/core/grid_mesh_normal_tangent_unit.sv]
// Grid mesh normal and tangent unit. Vertices arrive in row-major order; for each cell the
// unit returns the negated unit normal of the two cell edges and the negated unit edge tangent
// in signed fixed point, with the wrap-around results of the last column, last row and corner.
// One vertex is in work at a time. A vertex of row 0 is only written to the line store and
// gives no result; the result of any other vertex waits while the output register is full.
// Each vector of a cell passes the single shared normalizer: a normalizing shift, then the
// bit-serial square root and quotient loops; a zero-length vector skips these and is flagged
// degenerate. The final vertex of a grid also replays the stored first row from the result
// store. The stores need no clearing pass.
module grid_mesh_normal_tangent_unit #(
    parameter int MAX_COLUMNS    = 32,
    parameter int COORD_BITS     = 16,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    gmnt_in_if.sink                        i_vtx,
    gmnt_out_if.source                     o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gmnt_pkg::ADDR_W-1:0]    paddr,
    input  logic [gmnt_pkg::DATA_W-1:0]    pwdata,
    output logic [gmnt_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    localparam int CW  = gmnt_pkg::COL_W;
    localparam int RWD = gmnt_pkg::ROW_W;

    logic [CW-1:0]   r_grid_columns;
    logic [RWD-1:0]  r_grid_rows;
    logic            cfg_wr;
    logic            reg_sel;
    logic [CW-1:0]   eff_cols;
    logic [RWD-1:0]  eff_rows;
    gmnt_pkg::t_cmd  cmd;
    gmnt_pkg::t_stat stat;
    gmnt_pkg::t_res  res;
    logic            ready;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= CW'(32);
            r_grid_rows    <= RWD'(32);
        end else if (cfg_wr) begin
            case (reg_sel)
                gmnt_pkg::REG_GRID_COLUMNS: r_grid_columns <= pwdata[CW-1:0];
                gmnt_pkg::REG_GRID_ROWS:    r_grid_rows    <= pwdata[RWD-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            gmnt_pkg::REG_GRID_COLUMNS: prdata = gmnt_pkg::DATA_W'(r_grid_columns);
            gmnt_pkg::REG_GRID_ROWS:    prdata = gmnt_pkg::DATA_W'(r_grid_rows);
            default:                    prdata = '0;
        endcase
    end

    // grid size in use
    assign eff_cols = (r_grid_columns < CW'(2)) ? CW'(2) :
                      (r_grid_columns > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : r_grid_columns;
    assign eff_rows = (r_grid_rows < RWD'(2)) ? RWD'(2) : r_grid_rows;

    gmnt_ctrl #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_vtx.valid),
        .o_ready  (ready),
        .i_cfg_wr (cfg_wr),
        .i_cols   (eff_cols),
        .i_rows   (eff_rows),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    gmnt_dp #(
        .MAX_COLUMNS    (MAX_COLUMNS),
        .COORD_BITS     (COORD_BITS),
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_pos_x     (i_vtx.pos_x),
        .i_pos_y     (i_vtx.pos_y),
        .i_pos_z     (i_vtx.pos_z),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_col       (o_res.point_column),
        .o_row       (o_res.point_row),
        .o_res       (res),
        .o_last      (o_res.last_of_run)
    );

    // result transaction payload
    assign i_vtx.ready       = ready;
    assign o_res.normal_x    = res.nrm[0];
    assign o_res.normal_y    = res.nrm[1];
    assign o_res.normal_z    = res.nrm[2];
    assign o_res.tangent_x   = res.tan[0];
    assign o_res.tangent_y   = res.tan[1];
    assign o_res.tangent_z   = res.tan[2];
    assign o_res.degenerate  = res.deg;
endmodule
